// File: sv/tdtt_pkg.sv
package tdtt_pkg;

   localparam int unsigned TABLE_DEPTH_DEFAULT = 16;
   localparam int unsigned CAP_WIDTH = 5;
   localparam int unsigned TOL_WIDTH = 32;
   localparam int unsigned KEY_WIDTH = 64;
   localparam int unsigned TIME_WIDTH = 48;
   localparam int unsigned HEIGHT_WIDTH = 64;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd60000;

   localparam logic [0:0] REG_CAPACITY = 1'b0;
   localparam logic [0:0] REG_EXPIRE = 1'b1;

   typedef enum logic [2:0] {
      CMD_APPLY   = 3'd0,
      CMD_REFRESH = 3'd1,
      CMD_TOUCH   = 3'd2,
      CMD_GET     = 3'd3,
      CMD_REMOVE  = 3'd4,
      CMD_EXPIRE  = 3'd5,
      CMD_RSVD6   = 3'd6,
      CMD_RSVD7   = 3'd7
   } command_type;

   typedef struct packed {
      command_type command;
      logic [KEY_WIDTH-1:0] account_key;
      logic [TIME_WIDTH-1:0] now_ms;
      logic [HEIGHT_WIDTH-1:0] interval_low;
      logic [HEIGHT_WIDTH-1:0] interval_high;
      logic [HEIGHT_WIDTH-1:0] new_height;
   } req_type;

   typedef struct packed {
      logic ok;
      logic found;
      logic [HEIGHT_WIDTH-1:0] progress_height;
      logic [HEIGHT_WIDTH-1:0] stored_low;
      logic [HEIGHT_WIDTH-1:0] stored_high;
   } rsp_type;

   // result of one scan over the table
   typedef struct packed {
      logic hit;
      logic free_seen;
   } scan_type;

endpackage

// File: sv/tdtt_csr.sv
module tdtt_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:2]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic [tdtt_pkg::CAP_WIDTH-1:0] capacity_limit,
   output logic [tdtt_pkg::TOL_WIDTH-1:0] expire_after_ms
);
   logic [tdtt_pkg::CAP_WIDTH-1:0] cap_ff;
   logic [tdtt_pkg::TOL_WIDTH-1:0] tol_ff;
   logic wr;

   assign wr = csr_psel & csr_penable & csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= tdtt_pkg::CAP_RESET;
         tol_ff <= tdtt_pkg::TOL_RESET;
      end else if (wr) begin
         if (csr_paddr[2] == tdtt_pkg::REG_CAPACITY)
            cap_ff <= csr_pwdata[tdtt_pkg::CAP_WIDTH-1:0];
         else
            tol_ff <= csr_pwdata;
      end
   end

   always_comb begin
      if (csr_paddr[2] == tdtt_pkg::REG_EXPIRE) csr_prdata = tol_ff;
      else csr_prdata = {{(32-tdtt_pkg::CAP_WIDTH){1'b0}}, cap_ff};
   end

   assign capacity_limit = cap_ff;
   assign expire_after_ms = tol_ff;
endmodule

// File: sv/timed_download_tracker_table.sv
// channel  | ports                 | payload
// req      | req_valid, req_stall  | tdtt_pkg::req_type
// rsp      | rsp_valid, rsp_stall  | tdtt_pkg::rsp_type
// csr      | csr_p* (APB)          | capacity_limit @0, expire_after_ms @4
// Apply, refresh, touch and expire run, in order: an expiry pass, a key and
// free-slot pass, action, result load and handoff. Get, remove and unused
// codes skip the expiry pass. No new item is accepted until the result of the
// last one has been taken. Both passes visit the entries in turn through the
// single table read port and one compare unit. Reset is synchronous; it clears
// valid bits, live count and control state. A stalled result holds in its
// register and holds off the next item.
module timed_download_tracker_table #(
   parameter int unsigned TABLE_DEPTH = tdtt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  tdtt_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output tdtt_pkg::rsp_type rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:2]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EXPIRE, S_MATCH, S_ACT, S_RESP
   } state_type;

   logic [tdtt_pkg::CAP_WIDTH-1:0] cap;
   logic [tdtt_pkg::TOL_WIDTH-1:0] tol;

   tdtt_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .capacity_limit(cap), .expire_after_ms(tol)
   );
   assign csr_pready = 1'b1;

   // table storage
   logic [tdtt_pkg::KEY_WIDTH-1:0]    key_mem   [TABLE_DEPTH];
   logic [tdtt_pkg::HEIGHT_WIDTH-1:0] low_mem   [TABLE_DEPTH];
   logic [tdtt_pkg::HEIGHT_WIDTH-1:0] high_mem  [TABLE_DEPTH];
   logic [tdtt_pkg::HEIGHT_WIDTH-1:0] prog_mem  [TABLE_DEPTH];
   logic [tdtt_pkg::TIME_WIDTH-1:0]   stamp_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [CW-1:0] live_ff;

   state_type state_ff;
   tdtt_pkg::req_type req_ff;
   tdtt_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic [IW-1:0] idx_ff, slot_ff, free_ff;
   tdtt_pkg::scan_type scan_ff;
   logic last;

   assign last = (idx_ff == IW'(TABLE_DEPTH - 1));

   logic run_expiry;
   assign run_expiry = (req_ff.command == tdtt_pkg::CMD_APPLY) ||
                       (req_ff.command == tdtt_pkg::CMD_REFRESH) ||
                       (req_ff.command == tdtt_pkg::CMD_TOUCH) ||
                       (req_ff.command == tdtt_pkg::CMD_EXPIRE);

   logic [CW-1:0] limit;
   assign limit = (32'(cap) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cap);

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // sequencer
   always_ff @(posedge clock) begin
      logic [tdtt_pkg::TIME_WIDTH-1:0] age;
      logic stale;
      logic key_eq;
      tdtt_pkg::rsp_type rsp_in;
      // shared unit: age compare and key compare on the indexed entry
      age = req_ff.now_ms - stamp_mem[idx_ff];
      stale = valid_ff[idx_ff] && (age >= {16'd0, tol});
      key_eq = valid_ff[idx_ff] && (key_mem[idx_ff] == req_ff.account_key);
      rsp_in = '0;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         live_ff <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff <= req_data;
                  idx_ff <= '0;
                  state_ff <= S_EXPIRE;
               end
            end
            S_EXPIRE: begin
               if (run_expiry && stale) begin
                  valid_ff[idx_ff] <= 1'b0;
                  live_ff <= live_ff - CW'(1);
               end
               if (!run_expiry || last) begin
                  idx_ff <= '0;
                  scan_ff <= '0;
                  state_ff <= S_MATCH;
               end else idx_ff <= idx_ff + IW'(1);
            end
            S_MATCH: begin
               // first hit and first free slot win
               scan_ff <= {scan_ff.hit | key_eq, scan_ff.free_seen | ~valid_ff[idx_ff]};
               if (key_eq && !scan_ff.hit) slot_ff <= idx_ff;
               if (!valid_ff[idx_ff] && !scan_ff.free_seen) free_ff <= idx_ff;
               if (last) state_ff <= S_ACT;
               else idx_ff <= idx_ff + IW'(1);
            end
            S_ACT: begin
               rsp_in.found = scan_ff.hit;
               if (scan_ff.hit) begin
                  rsp_in.progress_height = prog_mem[slot_ff];
                  rsp_in.stored_low = low_mem[slot_ff];
                  rsp_in.stored_high = high_mem[slot_ff];
               end
               case (req_ff.command)
                  tdtt_pkg::CMD_APPLY: begin
                     if (!scan_ff.hit && live_ff < limit && scan_ff.free_seen) begin
                        valid_ff[free_ff] <= 1'b1;
                        key_mem[free_ff] <= req_ff.account_key;
                        low_mem[free_ff] <= req_ff.interval_low;
                        high_mem[free_ff] <= req_ff.interval_high;
                        prog_mem[free_ff] <= '0;
                        stamp_mem[free_ff] <= req_ff.now_ms;
                        live_ff <= live_ff + CW'(1);
                        rsp_in.ok = 1'b1;
                        rsp_in.stored_low = req_ff.interval_low;
                        rsp_in.stored_high = req_ff.interval_high;
                     end
                  end
                  tdtt_pkg::CMD_REFRESH: begin
                     if (scan_ff.hit && prog_mem[slot_ff] <= req_ff.new_height &&
                         req_ff.new_height <= high_mem[slot_ff]) begin
                        prog_mem[slot_ff] <= req_ff.new_height;
                        stamp_mem[slot_ff] <= req_ff.now_ms;
                        rsp_in.ok = 1'b1;
                        rsp_in.progress_height = req_ff.new_height;
                     end
                  end
                  tdtt_pkg::CMD_TOUCH: begin
                     if (scan_ff.hit) stamp_mem[slot_ff] <= req_ff.now_ms;
                     rsp_in.ok = scan_ff.hit;
                  end
                  tdtt_pkg::CMD_GET: rsp_in.ok = scan_ff.hit;
                  tdtt_pkg::CMD_REMOVE: begin
                     if (scan_ff.hit) begin
                        valid_ff[slot_ff] <= 1'b0;
                        live_ff <= live_ff - CW'(1);
                     end
                     rsp_in.ok = scan_ff.hit;
                  end
                  tdtt_pkg::CMD_EXPIRE: rsp_in.ok = 1'b1;
                  default: rsp_in = '0;
               endcase
               rsp_ff <= rsp_in;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: sv/tdtt_checker.sv
module tdtt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input tdtt_pkg::rsp_type rsp_data
);
   // a result comes only after an item has gone in
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without pending item");
   // no new item while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while result pending");
   // an accepted item keeps the input busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input free right after accept");
   // a failed command on an absent key reports no entry
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found && !rsp_data.ok) |->
         (rsp_data.progress_height == '0 && rsp_data.stored_low == '0 &&
          rsp_data.stored_high == '0))
      else $error("absent entry with nonzero fields");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");
endmodule

bind timed_download_tracker_table tdtt_checker u_tdtt_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
